### sv/shuffled_minstd_random_generator_core_macros.svh
`ifndef SHUFFLED_MINSTD_RANDOM_GENERATOR_CORE_MACROS_SVH
`define SHUFFLED_MINSTD_RANDOM_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMRG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrg assertion failed");

`endif

### sv/smrg_pkg.sv
package smrg_pkg;

    localparam int unsigned VAL_W = 31;

    typedef logic [VAL_W-1:0] t_val;

    localparam t_val        LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [14:0] LEHMER_MUL = 15'd16807;
    localparam t_val        CEIL_RESET = 31'd2147483389;
    localparam t_val        SEED_ONE   = 31'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM,
        S_SQUO,
        S_SFIX,
        S_DRAW,
        S_LOAD,
        S_FIX
    } t_state;

    typedef struct packed {
        logic seed_load;
        logic warm_step;
        logic draw;
        logic load_pick;
        logic quo_pick;
        logic fix_slot;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic out_free;
    } t_dp_sts;

    // The product is folded once, since 2^31 is congruent to 1 modulo 2^31-1.
    function automatic t_val lehmer_next(input t_val x);
        logic [45:0] prod;
        logic [31:0] fold;
        prod = 46'(x) * 46'(LEHMER_MUL);
        fold = {1'b0, prod[30:0]} + 32'(prod[45:31]);
        if (fold >= 32'(LEHMER_MOD)) begin
            fold = fold - 32'(LEHMER_MOD);
        end
        return fold[30:0];
    endfunction

    function automatic t_val seed_fix(input t_val s);
        return ((s == '0) || (s == LEHMER_MOD)) ? SEED_ONE : s;
    endfunction

endpackage

### sv/smrg_ifs.sv
interface smrg_req_if;
    import smrg_pkg::*;

    logic valid;
    logic ready;
    logic reseed;
    t_val seed_value;

    modport source (output valid, reseed, seed_value, input ready);
    modport sink (input valid, reseed, seed_value, output ready);
endinterface

interface smrg_rsp_if;
    import smrg_pkg::*;

    logic valid;
    logic ready;
    t_val random_value;

    modport source (output valid, random_value, input ready);
    modport sink (input valid, random_value, output ready);
endinterface

### sv/smrg_ctrl.sv
`include "shuffled_minstd_random_generator_core_macros.svh"

module smrg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_reseed,
    output logic           o_in_ready,
    output smrg_pkg::t_dp_cmd o_cmd,
    input  smrg_pkg::t_dp_sts i_sts
);
    import smrg_pkg::*;

    t_state r_fsm;
    t_state n_fsm;
    logic   r_seeded;
    logic   n_seeded;
    logic   need_seed;

    assign need_seed = i_reseed || !r_seeded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_seeded <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_seeded <= n_seeded;
        end
    end

    always_comb begin
        n_fsm    = r_fsm;
        n_seeded = r_seeded;
        case (r_fsm)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (need_seed) begin
                        n_fsm    = S_WARM;
                        n_seeded = 1'b1;
                    end else begin
                        n_fsm = S_LOAD;
                    end
                end
            end
            S_WARM: begin
                if (i_sts.cnt_zero) begin
                    n_fsm = S_SQUO;
                end
            end
            S_SQUO: n_fsm = S_SFIX;
            S_SFIX: n_fsm = S_DRAW;
            S_DRAW: n_fsm = S_LOAD;
            S_LOAD: n_fsm = S_FIX;
            S_FIX: begin
                if (i_sts.out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_fsm)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.seed_load = i_in_valid && need_seed;
                o_cmd.draw      = i_in_valid && !need_seed;
            end
            S_WARM: o_cmd.warm_step = 1'b1;
            S_SQUO: o_cmd.quo_pick  = 1'b1;
            S_SFIX: o_cmd.fix_slot  = 1'b1;
            S_DRAW: o_cmd.draw      = 1'b1;
            S_LOAD: o_cmd.load_pick = 1'b1;
            S_FIX: begin
                o_cmd.fix_slot = 1'b1;
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    `SMRG_ASSERT_NEXT(a_seed_first, i_clk, i_rst_n,
        (r_fsm == S_IDLE) && i_in_valid && !r_seeded, r_fsm == S_WARM)
    `SMRG_ASSERT_NEXT(a_warm_exit, i_clk, i_rst_n,
        (r_fsm == S_WARM) && i_sts.cnt_zero, r_fsm == S_SQUO)
    `SMRG_ASSERT_NEXT(a_fix_hold, i_clk, i_rst_n,
        (r_fsm == S_FIX) && !i_sts.out_free, r_fsm == S_FIX)

endmodule

### sv/smrg_datapath.sv
`include "shuffled_minstd_random_generator_core_macros.svh"

module smrg_datapath #(
    parameter int unsigned TABLE_SIZE   = 32,
    parameter int unsigned WARMUP_EXTRA = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smrg_pkg::t_dp_cmd i_cmd,
    output smrg_pkg::t_dp_sts o_sts,
    input  logic              i_reseed,
    input  smrg_pkg::t_val    i_seed_value,
    input  logic              i_cfg_we,
    input  smrg_pkg::t_val    i_cfg_wdata,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output smrg_pkg::t_val    o_random_value
);
    import smrg_pkg::*;

    localparam int unsigned     SLOT_W   = $clog2(TABLE_SIZE);
    localparam int unsigned     CNT_W    = $clog2(TABLE_SIZE + WARMUP_EXTRA + 1);
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483646 / TABLE_SIZE;
    localparam longint unsigned RECIP    = 64'h1_0000_0000 / SLOT_DIV;
    localparam int unsigned     RECIP_W  = $clog2(RECIP + 1);
    localparam int unsigned     QP_W     = VAL_W + RECIP_W;

    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_SIZE + WARMUP_EXTRA - 1);
    localparam logic [CNT_W-1:0] CNT_TABLE = CNT_W'(TABLE_SIZE);

    t_val              mem [TABLE_SIZE];
    t_val              r_lehmer;
    t_val              n_lehmer;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    t_val              r_rd;
    t_val              r_pick;
    logic [SLOT_W-1:0] r_q0;
    logic [SLOT_W-1:0] n_q0;
    t_val              r_ceiling;
    logic              r_out_valid;
    t_val              r_out_data;
    t_val              quo_src;
    logic [QP_W-1:0]   quo_prod;
    logic [31:0]       fix_prod;
    logic [31:0]       fix_rem;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_val              seed_src;

    assign n_lehmer = lehmer_next(r_lehmer);
    assign seed_src = seed_fix(i_reseed ? i_seed_value : SEED_ONE);

    // The estimate from the reciprocal is the slot or one below it.
    assign quo_src  = i_cmd.load_pick ? r_rd : r_pick;
    assign quo_prod = QP_W'(quo_src) * QP_W'(RECIP);
    assign n_q0     = SLOT_W'(quo_prod >> 32);

    assign fix_prod = 32'(r_q0) * 32'(SLOT_DIV);
    assign fix_rem  = {1'b0, r_pick} - fix_prod;
    assign n_slot   = (fix_rem >= 32'(SLOT_DIV)) ? SLOT_W'(r_q0 + SLOT_W'(1)) : r_q0;

    assign mem_we    = i_cmd.draw || (i_cmd.warm_step && (r_cnt < CNT_TABLE));
    assign mem_waddr = i_cmd.warm_step ? r_cnt[SLOT_W-1:0] : r_slot;

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling   <= CEIL_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_slot      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ceiling <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.seed_load) begin
                r_cnt <= CNT_START;
            end else if (i_cmd.warm_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.fix_slot) begin
                r_slot <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_lehmer <= seed_src;
        end else if (i_cmd.warm_step || i_cmd.draw) begin
            r_lehmer <= n_lehmer;
        end
        if (i_cmd.warm_step && o_sts.cnt_zero) begin
            r_pick <= n_lehmer;
        end else if (i_cmd.load_pick) begin
            r_pick <= r_rd;
        end
        if (i_cmd.load_pick || i_cmd.quo_pick) begin
            r_q0 <= n_q0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= (r_pick > r_ceiling) ? r_ceiling : r_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= n_lehmer;
        end
        if (i_cmd.draw) begin
            r_rd <= mem[r_slot];
        end
    end

    `SMRG_ASSERT_NEXT(a_lehmer_nonzero, i_clk, i_rst_n,
        i_cmd.warm_step || i_cmd.draw, r_lehmer != '0)

endmodule

### sv/shuffled_minstd_random_generator_core.sv
// Shuffled minimal-standard random generator with a Bays-Durham table.
// Requests arrive on i_req (valid/ready) with reseed and seed_value; each
// transfer yields exactly one random_value on o_rsp (valid/ready).
// The ceiling register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Larger picks are returned as the ceiling. A draw reads the table, estimates
// the slot and corrects it, each one register stage; the result is loaded into
// the output register with the slot correction, which holds while the output
// register is full, and the next request is taken once the result is loaded.
// A seeding request (reseed high, or the first one after reset) first runs
// TABLE_SIZE + WARMUP_EXTRA generator steps, one per cycle, then derives the
// first slot with an estimate and a correction, and reads the table before
// the draw.
// Reset clears the control state and sets the ceiling to its default; the
// table holds nothing until the first seeding fills it.
// The result sits in an output register, so a new request can be taken while
// the receiver stalls; the following result then waits in the slot correction
// until the earlier result is transferred.
module shuffled_minstd_random_generator_core #(
    parameter int unsigned TABLE_SIZE   = 32,
    parameter int unsigned WARMUP_EXTRA = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    smrg_req_if.sink       i_req,
    smrg_rsp_if.source     o_rsp,
    input  logic           i_cfg_we,
    input  smrg_pkg::t_val i_cfg_wdata
);
    import smrg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    smrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_reseed   (i_req.reseed),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    smrg_datapath #(
        .TABLE_SIZE   (TABLE_SIZE),
        .WARMUP_EXTRA (WARMUP_EXTRA)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_reseed       (i_req.reseed),
        .i_seed_value   (i_req.seed_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_random_value (o_rsp.random_value)
    );

endmodule
